### rtl/mit_pkg.sv
// Shared constants and types for the multi-interval alarm timer.
package mit_pkg;

  localparam int unsigned TICK_W     = 32;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned MAX_ALARMS = 4;

  localparam logic [1:0] REQ_CHECK   = 2'd0;
  localparam logic [1:0] REQ_START   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_COUNT = 3'd4;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

### rtl/mit_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module mit_rem import mit_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TICK_W-1:0] dividend_i,
  input  logic [TICK_W-1:0] divisor_i,
  output rem_status_t       status_o
);

  localparam int unsigned CNT_W = $clog2(TICK_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TICK_W - 1);

  logic [TICK_W-1:0] dvd_q, dvd_d;
  logic [TICK_W-1:0] dvs_q, dvs_d;
  logic [TICK_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [TICK_W:0]   trial;

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, dvd_q[TICK_W-1]};
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = TICK_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[TICK_W-1:0];
      end
      dvd_d = {dvd_q[TICK_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign status_o.done = !busy_q;
  assign status_o.zero = (rem_q == '0);

endmodule

### rtl/multi_interval_alarm_timer.sv
// Top level of the multi-interval alarm timer.
//
// Requests enter on the input channel (in_valid_i / in_stall_o) and each one
// yields exactly one result transaction on the output channel (out_valid_o /
// out_stall_i). Interval and count registers are written through the cfg
// channel (cfg_valid_i / cfg_ready_o, index 0..3 intervals, 4 alarm count);
// cfg_ready_o is always high and writes belong in idle periods.
// A start or restart request goes from idle to the finish state, which loads its
// result into the output register and returns to idle for the next request. A check
// request runs two bit-serial remainder units side by side, one dividend bit per
// cycle, and its result is loaded in the finish state once both are done; the block
// holds one request at a time, so a new check waits until that result is loaded.
// A finished result sits in the output register while the receiver stalls;
// the next request is taken meanwhile, and its result waits until the
// register frees up. Reset clears the intervals, the alarm count, the start
// mark and the active slot, and empties the output register.
module multi_interval_alarm_timer import mit_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [TICK_W-1:0]    now_tick_i,
  input  logic [TICK_W-1:0]    start_offset_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 alarm_hit_o,
  output logic [SLOT_W-1:0]    alarm_index_o,
  output logic                 at_start_o,
  output logic                 at_end_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0]  slot,
                                                   input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] v;
    logic [SLOT_W-1:0]  r;
    v = {1'b0, slot} + 1'b1;
    case (n)
      3'd1: r = '0;
      3'd2: r = {1'b0, v[0]};
      3'd3: r = (v == 3'd3) ? 2'd0 : (v == 3'd4) ? 2'd1 : v[SLOT_W-1:0];
      3'd4: r = (v == 3'd4) ? 2'd0 : v[SLOT_W-1:0];
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [TICK_W-1:0]  interval_q [MAX_ALARMS];
  logic [COUNT_W-1:0] count_q;
  logic [TICK_W-1:0]  start_mark_q, start_mark_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [1:0]         state_q, state_d;
  logic [1:0]         req_q;
  logic [TICK_W-1:0]  now_q;
  logic [TICK_W-1:0]  elapsed_q;
  logic [TICK_W-1:0]  ivl_q;

  logic               out_valid_q, out_valid_d;
  logic               hit_q, at_s_q, at_e_q;
  logic [SLOT_W-1:0]  idx_q;

  logic               in_acc, rem_start, fin_load;
  logic [TICK_W-1:0]  ivl_sel;
  rem_status_t        st_a, st_b;

  logic [COUNT_W-1:0] n_used;
  logic               is_check, alarms_on, negative, el_zero, fire;
  logic               hit_c, at_s_c, at_e_c;
  logic [SLOT_W-1:0]  idx_c, slot_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign rem_start   = in_acc && (req_type_i == REQ_CHECK);
  assign ivl_sel     = interval_q[slot_q];

  mit_rem u_rem_ivl (
    .clk_i,
    .rst_ni,
    .start_i    (rem_start),
    .dividend_i (now_tick_i - start_mark_q),
    .divisor_i  (ivl_sel),
    .status_o   (st_a)
  );

  mit_rem u_rem_end (
    .clk_i,
    .rst_ni,
    .start_i    (rem_start),
    .dividend_i (now_tick_i - start_mark_q),
    .divisor_i  (ivl_sel - 1'b1),
    .status_o   (st_b)
  );

  always_comb begin
    n_used    = (count_q > COUNT_W'(MAX_ALARMS)) ? COUNT_W'(MAX_ALARMS) : count_q;
    is_check  = (req_q == REQ_CHECK);
    alarms_on = (n_used != '0);
    negative  = elapsed_q[TICK_W-1];
    el_zero   = (elapsed_q == '0);
    fire      = is_check && alarms_on && !negative && !el_zero
                && ((ivl_q == '0) || st_a.zero);
    slot_fire = next_slot(slot_q, n_used);
    at_s_c    = is_check && el_zero && (slot_q == '0);
    at_e_c    = is_check && alarms_on
                && ((ivl_q <= TICK_W'(1)) || (!el_zero && st_b.zero));
    hit_c     = (is_check && alarms_on && !negative && el_zero) || fire;
    idx_c     = fire ? slot_fire : '0;
  end

  always_comb begin
    state_d      = state_q;
    start_mark_d = start_mark_q;
    slot_d       = slot_q;
    fin_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_START || req_type_i == REQ_RESTART) begin
            start_mark_d = now_tick_i + start_offset_i;
          end
          if (req_type_i == REQ_RESTART) begin
            slot_d = '0;
          end
          state_d = (req_type_i == REQ_CHECK) ? ST_CALC : ST_FIN;
        end
      end
      ST_CALC: begin
        if (st_a.done && st_b.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          fin_load = 1'b1;
          state_d  = ST_IDLE;
          if (fire) begin
            start_mark_d = now_q;
            slot_d       = slot_fire;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (fin_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      start_mark_q <= '0;
      slot_q       <= '0;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      for (int i = 0; i < MAX_ALARMS; i++) begin
        interval_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      start_mark_q <= start_mark_d;
      slot_q       <= slot_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_INTERVAL_A,
          CFG_INTERVAL_B,
          CFG_INTERVAL_C,
          CFG_INTERVAL_D: interval_q[cfg_index_i[SLOT_W-1:0]] <= cfg_data_i;
          CFG_ALARM_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= req_type_i;
      now_q     <= now_tick_i;
      elapsed_q <= now_tick_i - start_mark_q;
      ivl_q     <= ivl_sel;
    end
    if (fin_load) begin
      hit_q  <= hit_c;
      idx_q  <= idx_c;
      at_s_q <= at_s_c;
      at_e_q <= at_e_c;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign alarm_hit_o   = hit_q;
  assign alarm_index_o = idx_q;
  assign at_start_o    = at_s_q;
  assign at_end_o      = at_e_q;

endmodule

### rtl/mit_checker.sv
// Port-level checker for the multi-interval alarm timer, bound to the top level.
module mit_checker import mit_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 alarm_hit_o,
  input logic [SLOT_W-1:0]    alarm_index_o,
  input logic                 at_start_o,
  input logic                 at_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(alarm_hit_o)
      && $stable(alarm_index_o) && $stable(at_start_o) && $stable(at_end_o))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while one is in flight");

  a_idx_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !alarm_hit_o |-> alarm_index_o == '0)
    else $error("alarm index set without a hit");

  a_start_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_start_o |-> alarm_index_o == '0)
    else $error("at_start with nonzero alarm index");

endmodule

bind multi_interval_alarm_timer mit_checker u_mit_checker (.*);

### sim/mit_alarm_checker.sv
// Checker for the multi-interval alarm timer: predicts each result and compares it.
module mit_alarm_checker import mit_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [1:0]           req_type_i,
  input  logic [TICK_W-1:0]    now_tick_i,
  input  logic [TICK_W-1:0]    start_offset_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 alarm_hit_i,
  input  logic [SLOT_W-1:0]    alarm_index_i,
  input  logic                 at_start_i,
  input  logic                 at_end_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i,
  output int unsigned          pending_o,
  output int unsigned          fail_cnt_o,
  output int unsigned          result_cnt_o,
  output int unsigned          hit_cnt_o,
  output int unsigned          start_flag_cnt_o,
  output int unsigned          end_flag_cnt_o
);

  localparam int unsigned MAX_REPORTS = 40;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] index;
    logic              at_start;
    logic              at_end;
  } alarm_flags_t;

  logic [TICK_W-1:0]  span_tick [MAX_ALARMS];
  logic [COUNT_W-1:0] slots_cfg;
  logic [TICK_W-1:0]  mark_tick;
  logic [SLOT_W-1:0]  cur_slot;
  alarm_flags_t       expected_flags_q [$];

  function automatic alarm_flags_t predict_alarm(logic [1:0] req, logic [TICK_W-1:0] now,
                                                 logic [TICK_W-1:0] off);
    alarm_flags_t       res;
    logic [COUNT_W-1:0] used;
    logic [TICK_W-1:0]  elapsed;
    logic [TICK_W-1:0]  span;
    res = '0;
    case (req)
      REQ_START: begin
        mark_tick = now + off;
      end
      REQ_RESTART: begin
        mark_tick = now + off;
        cur_slot  = '0;
      end
      REQ_CHECK: begin
        used    = (slots_cfg > COUNT_W'(MAX_ALARMS)) ? COUNT_W'(MAX_ALARMS) : slots_cfg;
        elapsed = now - mark_tick;
        span    = span_tick[cur_slot];
        res.at_start = (elapsed == '0) && (cur_slot == '0);
        if (used != '0) begin
          if (span <= 1) begin
            res.at_end = 1'b1;
          end else if (elapsed != '0) begin
            res.at_end = ((elapsed % (span - 1)) == '0);
          end
          if (!elapsed[TICK_W-1]) begin
            if (elapsed == '0) begin
              res.hit = 1'b1;
            end else if ((span == '0) || ((elapsed % span) == '0)) begin
              mark_tick = now;
              cur_slot  = SLOT_W'((cur_slot + 1) % used);
              res.hit   = 1'b1;
              res.index = cur_slot;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(string field, logic [SLOT_W-1:0] want, logic [SLOT_W-1:0] got);
    if (got !== want) begin
      fail_cnt_o++;
      if (fail_cnt_o <= MAX_REPORTS) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    alarm_flags_t got;
    alarm_flags_t want;
    if (!rst_ni) begin
      span_tick        = '{default: '0};
      slots_cfg        = '0;
      mark_tick        = '0;
      cur_slot         = '0;
      expected_flags_q.delete();
      fail_cnt_o       = 0;
      result_cnt_o     = 0;
      hit_cnt_o        = 0;
      start_flag_cnt_o = 0;
      end_flag_cnt_o   = 0;
      pending_o       <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_INTERVAL_A, CFG_INTERVAL_B, CFG_INTERVAL_C, CFG_INTERVAL_D: begin
            span_tick[cfg_index_i[SLOT_W-1:0]] = cfg_data_i;
          end
          CFG_ALARM_COUNT: begin
            slots_cfg = cfg_data_i[COUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = {alarm_hit_i, alarm_index_i, at_start_i, at_end_i};
        result_cnt_o++;
        if (got.hit === 1'b1) hit_cnt_o++;
        if (got.at_start === 1'b1) start_flag_cnt_o++;
        if (got.at_end === 1'b1) end_flag_cnt_o++;
        if (expected_flags_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= MAX_REPORTS) begin
            $display("%0t: result transaction expected none actual %h", $time, got);
          end
        end else begin
          want = expected_flags_q.pop_front();
          compare_field("alarm_hit", SLOT_W'(want.hit), SLOT_W'(got.hit));
          compare_field("alarm_index", want.index, got.index);
          compare_field("at_start", SLOT_W'(want.at_start), SLOT_W'(got.at_start));
          compare_field("at_end", SLOT_W'(want.at_end), SLOT_W'(got.at_end));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_flags_q.push_back(predict_alarm(req_type_i, now_tick_i, start_offset_i));
      end
      pending_o <= expected_flags_q.size();
    end
  end

endmodule

### sim/tb.sv
// Testbench top for the multi-interval alarm timer: stimulus, idling and verdict.
module tb;
  import mit_pkg::*;

  localparam logic [1:0]  REQ_UNUSED     = 2'd3;
  localparam int unsigned ITEM_TARGET    = 1600;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           req_type_i     = REQ_CHECK;
  logic [TICK_W-1:0]    now_tick_i     = '0;
  logic [TICK_W-1:0]    start_offset_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic                 alarm_hit_o;
  logic [SLOT_W-1:0]    alarm_index_o;
  logic                 at_start_o;
  logic                 at_end_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = CFG_INTERVAL_A;
  logic [TICK_W-1:0]    cfg_data_i     = '0;

  int unsigned sent_cnt    = 0;
  int unsigned cfg_cnt     = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_run   = 0;
  int unsigned pending;
  int unsigned fail_cnt;
  int unsigned result_cnt;
  int unsigned hit_cnt;
  int unsigned start_flag_cnt;
  int unsigned end_flag_cnt;

  always #5 clk_i = ~clk_i;

  multi_interval_alarm_timer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .now_tick_i     (now_tick_i),
    .start_offset_i (start_offset_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alarm_hit_o    (alarm_hit_o),
    .alarm_index_o  (alarm_index_o),
    .at_start_o     (at_start_o),
    .at_end_o       (at_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  mit_alarm_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .req_type_i       (req_type_i),
    .now_tick_i       (now_tick_i),
    .start_offset_i   (start_offset_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .alarm_hit_i      (alarm_hit_o),
    .alarm_index_i    (alarm_index_o),
    .at_start_i       (at_start_o),
    .at_end_i         (at_end_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .pending_o        (pending),
    .fail_cnt_o       (fail_cnt),
    .result_cnt_o     (result_cnt),
    .hit_cnt_o        (hit_cnt),
    .start_flag_cnt_o (start_flag_cnt),
    .end_flag_cnt_o   (end_flag_cnt)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run   <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_run   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic [1:0] req, logic [TICK_W-1:0] now,
                              logic [TICK_W-1:0] off);
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    now_tick_i     <= now;
    start_offset_i <= off;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_cnt++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_cnt++;
  endtask

  task automatic load_config(logic [TICK_W-1:0] span_a, logic [TICK_W-1:0] span_b,
                             logic [TICK_W-1:0] span_c, logic [TICK_W-1:0] span_d,
                             logic [COUNT_W-1:0] count);
    write_register(CFG_INTERVAL_A, span_a);
    write_register(CFG_INTERVAL_B, span_b);
    write_register(CFG_INTERVAL_C, span_c);
    write_register(CFG_INTERVAL_D, span_d);
    write_register(CFG_ALARM_COUNT, TICK_W'(count));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [TICK_W-1:0] random_span();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom;
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] random_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COUNT_W'($urandom_range(MAX_ALARMS + 1, 7));
      default: return COUNT_W'($urandom_range(1, MAX_ALARMS));
    endcase
  endfunction

  task automatic run_session();
    logic [TICK_W-1:0] tick;
    logic [TICK_W-1:0] off;
    int unsigned       len;
    tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 60) : $urandom;
    off  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
    send_request(($urandom_range(0, 1) != 0) ? REQ_RESTART : REQ_START, tick, off);
    len = $urandom_range(8, 40);
    repeat (len) begin
      if ($urandom_range(0, 11) == 0) begin
        send_request(2'($urandom_range(0, 3)), $urandom, $urandom);
      end else begin
        tick += $urandom_range(0, 3);
        send_request(REQ_CHECK, tick, $urandom);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(REQ_CHECK, '0, '0);
    send_request(REQ_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();
    load_config('0, 32'd1, 32'd5, 32'hFFFF_FFFF, COUNT_W'(MAX_ALARMS));
    send_request(REQ_RESTART, 32'd100, '0);
    send_request(REQ_CHECK, 32'd100, '0);
    send_request(REQ_CHECK, 32'd101, '0);
    send_request(REQ_CHECK, 32'd102, '0);
    send_request(REQ_CHECK, 32'd104, '0);
    send_request(REQ_CHECK, 32'd106, '0);
    send_request(REQ_CHECK, 32'd107, '0);
    send_request(REQ_CHECK, 32'd106, '0);
    send_request(REQ_START, 32'hFFFF_FFF0, 32'h20);
    send_request(REQ_CHECK, 32'h10, '0);
    send_request(REQ_START, '0, 32'h8000_0000);
    send_request(REQ_CHECK, '0, '0);
    send_request(REQ_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_CHECK, 32'hFFFF_FFFE, '0);
    wait_idle();
    load_config(32'd2, 32'd3, 32'd1, '0, 3'd7);

    while (sent_cnt < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        load_config(random_span(), random_span(), random_span(), random_span(), random_count());
      end
      run_session();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d requests and %0d register writes over many interval settings.",
             sent_cnt, cfg_cnt);
    $display("Saw %0d results: %0d alarm hits, %0d at_start, %0d at_end.",
             result_cnt, hit_cnt, start_flag_cnt, end_flag_cnt);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
